>>> rtl/core/mmsp_pkg.sv
`default_nettype none
package mmsp_pkg;

  localparam int unsigned MAX_VERTICES = 1024;
  localparam int unsigned MAX_EDGES    = 4096;
  localparam int unsigned WEIGHT_SETS  = 4;
  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned EW = $clog2(MAX_EDGES);
  localparam int unsigned SW = $clog2(WEIGHT_SETS);
  localparam logic [30:0] INF_DIST = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    F_WVERT = 2'd0,
    F_WEDGE = 2'd1,
    F_RUN   = 2'd2,
    F_READ  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    R_VCOUNT = 2'd0,
    R_ECOUNT = 2'd1,
    R_WSET   = 2'd2,
    R_NONE   = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_RDW, S_IV, S_IVW, S_TCLR, S_DRD, S_DT, S_DW,
    S_SRD, S_SCMP, S_PRD, S_PCHK, S_PEND, S_ERD, S_ET, S_EUP, S_DONE
  } state_t;

  typedef struct packed {
    logic [12:0] es;
    logic        kind;
    logic        src;
  } vrec_t;

  typedef struct packed {
    logic [30:0] dval;
    logic        done;
    logic [12:0] pend;
    logic [31:0] acc;
  } vst_t;

endpackage
`default_nettype wire

>>> rtl/core/min_max_node_shortest_path.sv
// Min/max node shortest path engine over a graph held in CSR form.
// Input channel (in_valid/in_stall): one beat per item, func selects
// write vertex, write edge, run search or read distance. Every item gives
// exactly one result beat on the output channel (out_valid/out_stall).
// Config channel (cfg_valid/cfg_ready) is always ready; write only while
// the block is idle.
// Vertex and edge writes are accepted back to back while out_stall is low.
// A read goes through the S_RDW state (registered distance memory read).
// A run steps through vertex setup over all 1024 vertex slots, clearing
// the traversal flags, in-degree counting over the in-use edges, then per
// picked vertex a scan of vertex_count vertices through the single compare
// unit, setup and wrap-up, and a pass over each of its edges.
// After reset a clearing pass over all 1024 vertex slots resets source
// marks and distances; in_stall is high during it.
// A result beat waits in the output register while out_stall is high;
// no new item is taken until it can be replaced.
`default_nettype none
module min_max_node_shortest_path (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [11:0] in_index,
  input  wire logic [12:0] in_edge_start,
  input  wire logic        in_is_max,
  input  wire logic        in_is_source,
  input  wire logic [9:0]  in_target,
  input  wire logic [15:0] in_weight,
  input  wire logic [1:0]  in_set_select,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [30:0]      out_distance,
  output logic             out_reached,
  output logic [10:0]      out_expanded,
  output logic             out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);

  localparam int unsigned NV = mmsp_pkg::MAX_VERTICES;
  localparam int unsigned NE = mmsp_pkg::MAX_EDGES;
  localparam int unsigned VW = mmsp_pkg::VW;
  localparam int unsigned EW = mmsp_pkg::EW;
  localparam int unsigned SW = mmsp_pkg::SW;

  mmsp_pkg::vrec_t vrec_mem [NV];
  mmsp_pkg::vst_t  vst_mem  [NV];
  logic [9:0]      tgt_mem  [NE];
  logic [15:0]     wt_mem   [NE*mmsp_pkg::WEIGHT_SETS];
  logic            trav_mem [NE];

  mmsp_pkg::vrec_t vrec_q, vrec_wd;
  mmsp_pkg::vst_t  vst_q, vst_wd;
  logic [9:0]      tgt_q, tgt_wd;
  logic [15:0]     wt_q, wt_wd;
  logic            trav_q, trav_wd;
  logic [VW-1:0]   vrec_ra, vrec_wa, vst_ra, vst_wa;
  logic [EW-1:0]   tgt_ra, tgt_wa, trav_ra, trav_wa;
  logic [SW+EW-1:0] wt_ra, wt_wa;
  logic            vrec_we, vst_we, tgt_we, wt_we, trav_we;

  mmsp_pkg::state_t state_r, state_nxt;
  logic [10:0] vcount_r;
  logic [12:0] ecount_r;
  logic [1:0]  wset_r;
  logic [12:0] cnt_r, cnt_nxt;
  logic [30:0] best_r, best_nxt;
  logic [VW-1:0] pick_r, pick_nxt;
  logic        found_r, found_nxt;
  logic [12:0] ecur_r, ecur_nxt, eend_r, eend_nxt;
  logic [10:0] exp_r, exp_nxt;
  logic [9:0]  tgt_r, tgt_nxt;
  logic [15:0] w_r, w_nxt;
  logic        trv_r, trv_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [30:0] out_distance_r, out_distance_nxt;
  logic        out_reached_r, out_reached_nxt;
  logic [10:0] out_expanded_r, out_expanded_nxt;
  logic        out_status_r, out_status_nxt;

  logic        oload_ok, in_acc;
  logic [10:0] vc;
  logic [12:0] ec;
  logic [11:0] pick_p1;
  logic        pick_max, tgt_max;
  logic [31:0] sum;
  logic [30:0] arrival;
  logic [12:0] pend_new;
  logic [31:0] acc_new;
  mmsp_pkg::vst_t vst_upd;

  assign vc = (vcount_r > 11'(NV)) ? 11'(NV) : vcount_r;
  assign ec = (ecount_r > 13'(NE)) ? 13'(NE) : ecount_r;
  assign oload_ok = !out_valid_r || !out_stall;
  assign in_stall = !(state_r == mmsp_pkg::S_IDLE && oload_ok);
  assign in_acc = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign pick_p1 = {2'b0, pick_r} + 12'd1;
  assign pick_max = vrec_q.kind && !vrec_q.src;
  assign tgt_max = vrec_q.kind && !vrec_q.src;

  assign sum = {1'b0, best_r} + {16'd0, w_r};
  assign arrival = (sum > {1'b0, mmsp_pkg::INF_DIST}) ? mmsp_pkg::INF_DIST : sum[30:0];
  assign pend_new = (!trv_r && vst_q.pend != 13'd0) ? vst_q.pend - 13'd1 : vst_q.pend;
  assign acc_new = (vst_q.acc < {1'b0, arrival}) ? {1'b0, arrival} : vst_q.acc;

  always_comb begin
    vst_upd = vst_q;
    vst_upd.pend = pend_new;
    if (!tgt_max) begin
      if (!vst_q.done && arrival < vst_q.dval) vst_upd.dval = arrival;
    end else begin
      vst_upd.acc = acc_new;
      if (pend_new == 13'd0) vst_upd.dval = acc_new[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (vrec_we) vrec_mem[vrec_wa] <= vrec_wd;
    vrec_q <= vrec_mem[vrec_ra];
    if (vst_we) vst_mem[vst_wa] <= vst_wd;
    vst_q <= vst_mem[vst_ra];
    if (tgt_we) tgt_mem[tgt_wa] <= tgt_wd;
    tgt_q <= tgt_mem[tgt_ra];
    if (wt_we) wt_mem[wt_wa] <= wt_wd;
    wt_q <= wt_mem[wt_ra];
    if (trav_we) trav_mem[trav_wa] <= trav_wd;
    trav_q <= trav_mem[trav_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mmsp_pkg::S_CLR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      vcount_r    <= 11'd1;
      ecount_r    <= '0;
      wset_r      <= '0;
      exp_r       <= '0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      exp_r       <= exp_nxt;
      found_r     <= found_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (mmsp_pkg::reg_idx_t'(cfg_index))
          mmsp_pkg::R_VCOUNT: vcount_r <= cfg_data[10:0];
          mmsp_pkg::R_ECOUNT: ecount_r <= cfg_data;
          mmsp_pkg::R_WSET:   wset_r   <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    best_r         <= best_nxt;
    pick_r         <= pick_nxt;
    ecur_r         <= ecur_nxt;
    eend_r         <= eend_nxt;
    tgt_r          <= tgt_nxt;
    w_r            <= w_nxt;
    trv_r          <= trv_nxt;
    out_distance_r <= out_distance_nxt;
    out_reached_r  <= out_reached_nxt;
    out_expanded_r <= out_expanded_nxt;
    out_status_r   <= out_status_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    best_nxt = best_r;
    pick_nxt = pick_r;
    found_nxt = found_r;
    ecur_nxt = ecur_r;
    eend_nxt = eend_r;
    exp_nxt = exp_r;
    tgt_nxt = tgt_r;
    w_nxt = w_r;
    trv_nxt = trv_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_distance_nxt = out_distance_r;
    out_reached_nxt = out_reached_r;
    out_expanded_nxt = out_expanded_r;
    out_status_nxt = out_status_r;
    vrec_we = 1'b0; vrec_wa = cnt_r[VW-1:0]; vrec_wd = '0; vrec_ra = cnt_r[VW-1:0];
    vst_we = 1'b0;  vst_wa = cnt_r[VW-1:0];  vst_wd = '0;  vst_ra = cnt_r[VW-1:0];
    tgt_we = 1'b0;  tgt_wa = in_index;       tgt_wd = in_target; tgt_ra = cnt_r[EW-1:0];
    wt_we = 1'b0;   wt_wa = {in_set_select, in_index}; wt_wd = in_weight;
    wt_ra = {wset_r, ecur_r[EW-1:0]};
    trav_we = 1'b0; trav_wa = cnt_r[EW-1:0]; trav_wd = 1'b0; trav_ra = ecur_r[EW-1:0];

    unique case (state_r)
      mmsp_pkg::S_CLR: begin
        vrec_we = 1'b1;
        vst_we = 1'b1;
        vst_wd.dval = mmsp_pkg::INF_DIST;
        cnt_nxt = cnt_r + 13'd1;
        if (cnt_r == 13'(NV - 1)) begin
          cnt_nxt = '0;
          state_nxt = mmsp_pkg::S_IDLE;
        end
      end
      mmsp_pkg::S_IDLE: begin
        if (in_acc) begin
          out_distance_nxt = '0;
          out_reached_nxt = 1'b0;
          out_expanded_nxt = '0;
          out_status_nxt = 1'b0;
          unique case (mmsp_pkg::func_t'(in_func))
            mmsp_pkg::F_WVERT: begin
              out_valid_nxt = 1'b1;
              if ({1'b0, in_index} < 13'(NV)) begin
                vrec_we = 1'b1;
                vrec_wa = in_index[VW-1:0];
                vrec_wd = '{es: in_edge_start, kind: in_is_max, src: in_is_source};
              end else out_status_nxt = 1'b1;
            end
            mmsp_pkg::F_WEDGE: begin
              out_valid_nxt = 1'b1;
              if ({1'b0, in_index} < 13'(NE) &&
                  {3'b0, in_set_select} < 5'(mmsp_pkg::WEIGHT_SETS)) begin
                tgt_we = 1'b1;
                wt_we = 1'b1;
              end else out_status_nxt = 1'b1;
            end
            mmsp_pkg::F_RUN: begin
              cnt_nxt = '0;
              exp_nxt = '0;
              state_nxt = mmsp_pkg::S_IV;
            end
            mmsp_pkg::F_READ: begin
              if ({1'b0, in_index} < 13'(NV)) begin
                vst_ra = in_index[VW-1:0];
                state_nxt = mmsp_pkg::S_RDW;
              end else begin
                out_valid_nxt = 1'b1;
                out_status_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      mmsp_pkg::S_RDW: begin
        out_valid_nxt = 1'b1;
        out_distance_nxt = vst_q.dval;
        out_reached_nxt = vst_q.dval != mmsp_pkg::INF_DIST;
        state_nxt = mmsp_pkg::S_IDLE;
      end
      mmsp_pkg::S_IV: begin
        if (cnt_r == 13'(NV)) begin
          cnt_nxt = '0;
          state_nxt = mmsp_pkg::S_TCLR;
        end else state_nxt = mmsp_pkg::S_IVW;
      end
      mmsp_pkg::S_IVW: begin
        vst_we = 1'b1;
        vst_wd.dval = vrec_q.src ? 31'd0 : mmsp_pkg::INF_DIST;
        vst_wd.acc = pick_max ? 32'd0 : 32'hFFFF_FFFF;
        cnt_nxt = cnt_r + 13'd1;
        state_nxt = mmsp_pkg::S_IV;
      end
      mmsp_pkg::S_TCLR: begin
        trav_we = 1'b1;
        cnt_nxt = cnt_r + 13'd1;
        if (cnt_r == 13'(NE - 1)) begin
          cnt_nxt = '0;
          state_nxt = mmsp_pkg::S_DRD;
        end
      end
      mmsp_pkg::S_DRD: begin
        if (cnt_r >= ec) begin
          cnt_nxt = '0;
          best_nxt = mmsp_pkg::INF_DIST;
          found_nxt = 1'b0;
          state_nxt = mmsp_pkg::S_SRD;
        end else state_nxt = mmsp_pkg::S_DT;
      end
      mmsp_pkg::S_DT: begin
        vst_ra = tgt_q;
        tgt_nxt = tgt_q;
        state_nxt = mmsp_pkg::S_DW;
      end
      mmsp_pkg::S_DW: begin
        vst_we = 1'b1;
        vst_wa = tgt_r;
        vst_wd = vst_q;
        vst_wd.pend = vst_q.pend + 13'd1;
        cnt_nxt = cnt_r + 13'd1;
        state_nxt = mmsp_pkg::S_DRD;
      end
      mmsp_pkg::S_SRD: begin
        if (cnt_r >= {2'b0, vc}) begin
          state_nxt = found_r ? mmsp_pkg::S_PRD : mmsp_pkg::S_DONE;
        end else state_nxt = mmsp_pkg::S_SCMP;
      end
      mmsp_pkg::S_SCMP: begin
        if (!vst_q.done && vst_q.dval != mmsp_pkg::INF_DIST && vst_q.dval <= best_r) begin
          best_nxt = vst_q.dval;
          pick_nxt = cnt_r[VW-1:0];
          found_nxt = 1'b1;
        end
        cnt_nxt = cnt_r + 13'd1;
        state_nxt = mmsp_pkg::S_SRD;
      end
      mmsp_pkg::S_PRD: begin
        vst_ra = pick_r;
        vrec_ra = pick_r;
        state_nxt = mmsp_pkg::S_PCHK;
      end
      mmsp_pkg::S_PCHK: begin
        vst_we = 1'b1;
        vst_wa = pick_r;
        vst_wd = vst_q;
        vst_wd.done = 1'b1;
        if (pick_max && vst_q.pend != 13'd0) begin
          cnt_nxt = '0;
          best_nxt = mmsp_pkg::INF_DIST;
          found_nxt = 1'b0;
          state_nxt = mmsp_pkg::S_SRD;
        end else begin
          exp_nxt = exp_r + 11'd1;
          ecur_nxt = vrec_q.es;
          if (pick_p1 < {1'b0, vc}) begin
            vrec_ra = pick_p1[VW-1:0];
            state_nxt = mmsp_pkg::S_PEND;
          end else begin
            eend_nxt = ec;
            state_nxt = mmsp_pkg::S_ERD;
          end
        end
      end
      mmsp_pkg::S_PEND: begin
        eend_nxt = (vrec_q.es > ec) ? ec : vrec_q.es;
        state_nxt = mmsp_pkg::S_ERD;
      end
      mmsp_pkg::S_ERD: begin
        tgt_ra = ecur_r[EW-1:0];
        if (ecur_r >= eend_r) begin
          cnt_nxt = '0;
          best_nxt = mmsp_pkg::INF_DIST;
          found_nxt = 1'b0;
          state_nxt = mmsp_pkg::S_SRD;
        end else state_nxt = mmsp_pkg::S_ET;
      end
      mmsp_pkg::S_ET: begin
        trav_we = 1'b1;
        trav_wa = ecur_r[EW-1:0];
        trav_wd = 1'b1;
        vst_ra = tgt_q;
        vrec_ra = tgt_q;
        tgt_nxt = tgt_q;
        w_nxt = wt_q;
        trv_nxt = trav_q;
        state_nxt = mmsp_pkg::S_EUP;
      end
      mmsp_pkg::S_EUP: begin
        vst_we = 1'b1;
        vst_wa = tgt_r;
        vst_wd = vst_upd;
        if (tgt_r == pick_r) best_nxt = vst_upd.dval;
        ecur_nxt = ecur_r + 13'd1;
        state_nxt = mmsp_pkg::S_ERD;
      end
      mmsp_pkg::S_DONE: begin
        if (oload_ok) begin
          out_valid_nxt = 1'b1;
          out_distance_nxt = '0;
          out_reached_nxt = 1'b0;
          out_expanded_nxt = exp_r;
          out_status_nxt = 1'b0;
          state_nxt = mmsp_pkg::S_IDLE;
        end
      end
      default: state_nxt = mmsp_pkg::S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_reached = out_reached_r;
  assign out_expanded = out_expanded_r;
  assign out_status = out_status_r;

  a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_func == mmsp_pkg::F_RUN |=> state_r == mmsp_pkg::S_IV)
    else $error("run item did not start setup");
  a_exp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_expanded_r <= 11'(NV))
    else $error("expanded count above vertex store depth");
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r |-> out_distance_r == 31'd0 && !out_reached_r)
    else $error("bad index beat carries a distance");
  a_reached: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_reached_r |-> out_distance_r != mmsp_pkg::INF_DIST)
    else $error("reached flag on infinite distance");

endmodule
`default_nettype wire
